// ===== src/pmre_pkg.sv =====
package pmre_pkg;

    // Port widths of the access and result fields.
    localparam int PAGE_W = 6;
    localparam int FRAME_W = 4;

    // Number of distinct codes the victim field can carry.
    localparam int VICTIM_CODES = 2 ** FRAME_W;

endpackage

// ===== src/pmre_ram.sv =====
module pmre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                         i_wdata,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port, registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/page_map_with_random_eviction_top.sv =====
// Page map with random eviction.
//
// An access is one beat on the command channel: it is taken at a rising edge
// where start is high and busy is low, carrying i_page_index and
// i_victim_frame. The block answers every access with exactly one result beat:
// o_valid is high for one cycle with o_frame_index, o_page_fault, o_did_evict
// and o_evicted_page. The receiver cannot hold results off, so none is needed.
//
// The single-port page map memory is visited once per dependent step. A
// hit, a fault into a free frame, or an out-of-range page is answered from
// state S_PAGE. A fault that evicts reads the owner table, reads the owner's
// page entry, clears it if it still points at the victim and maps the new
// page. Busy stays high until the result is shown, so one access is in
// flight at a time.
//
// After reset the page map is swept to invalid, one entry per cycle, with
// busy high until all NUM_PAGES entries are cleared. Free frames are always
// handed out in ascending order and never released, so a fill count stands
// in for the per-frame busy flags. The owner table needs no clearing.
module page_map_with_random_eviction_top #(
    parameter int NUM_PAGES = 64,
    parameter int NUM_FRAMES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pmre_pkg::PAGE_W-1:0]   i_page_index,
    input  logic [pmre_pkg::FRAME_W-1:0]  i_victim_frame,
    output logic                          o_valid,
    output logic [pmre_pkg::FRAME_W-1:0]  o_frame_index,
    output logic                          o_page_fault,
    output logic                          o_did_evict,
    output logic [pmre_pkg::PAGE_W-1:0]   o_evicted_page
);

    localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int MW = FW + 1;
    localparam int OFW = pmre_pkg::FRAME_W;
    localparam int OPW = pmre_pkg::PAGE_W;

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PAGE  = 3'd2;
    localparam logic [2:0] S_OWNER = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_MAP   = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [PW-1:0] r_clr, n_clr;
    logic [CW-1:0] r_fill, n_fill;
    logic [PW-1:0] r_page, n_page;
    logic [FW-1:0] r_victim, n_victim;
    logic          r_oor, n_oor;
    logic [PW-1:0] r_owner, n_owner;
    logic          r_valid, n_valid;
    logic [OFW-1:0] r_frame_out, n_frame_out;
    logic          r_fault, n_fault;
    logic          r_evict, n_evict;
    logic [OPW-1:0] r_gone, n_gone;

    // Page map memory: valid bit on top of the frame number.
    logic          pm_we;
    logic [PW-1:0] pm_addr;
    logic [MW-1:0] pm_wdata;
    logic [MW-1:0] pm_rdata;

    // Frame owner memory.
    logic          ow_we;
    logic [FW-1:0] ow_addr;
    logic [PW-1:0] ow_wdata;
    logic [PW-1:0] ow_rdata;

    logic [15:0]   w_page_ext;
    logic          w_page_oor;
    logic [FW-1:0] w_victim_lut [pmre_pkg::VICTIM_CODES];
    logic [FW-1:0] w_free;

    // The victim code is folded into the frame range through a constant table.
    for (genvar gv = 0; gv < pmre_pkg::VICTIM_CODES; gv++) begin : g_victim
        assign w_victim_lut[gv] = FW'(gv % NUM_FRAMES);
    end

    assign w_page_ext = 16'(i_page_index);
    assign w_page_oor = (w_page_ext >= 16'(NUM_PAGES));
    assign w_free     = r_fill[FW-1:0];

    pmre_ram #(
        .WIDTH (MW),
        .DEPTH (NUM_PAGES)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (pm_we),
        .i_addr  (pm_addr),
        .i_wdata (pm_wdata),
        .o_rdata (pm_rdata)
    );

    pmre_ram #(
        .WIDTH (PW),
        .DEPTH (NUM_FRAMES)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (ow_we),
        .i_addr  (ow_addr),
        .i_wdata (ow_wdata),
        .o_rdata (ow_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_fill      = r_fill;
        n_page      = r_page;
        n_victim    = r_victim;
        n_oor       = r_oor;
        n_owner     = r_owner;
        n_valid     = 1'b0;
        n_frame_out = r_frame_out;
        n_fault     = r_fault;
        n_evict     = r_evict;
        n_gone      = r_gone;
        pm_we       = 1'b0;
        pm_addr     = r_page;
        pm_wdata    = '0;
        ow_we       = 1'b0;
        ow_addr     = r_victim;
        ow_wdata    = r_page;

        unique case (r_state)
            S_CLEAR: begin
                // Sweep every page entry to invalid.
                pm_we   = 1'b1;
                pm_addr = r_clr;
                n_clr   = r_clr + 1'b1;
                if (r_clr == PW'(NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_page   = w_page_ext[PW-1:0];
                    n_victim = w_victim_lut[i_victim_frame];
                    n_oor    = w_page_oor;
                    pm_addr  = w_page_ext[PW-1:0];
                    n_state  = S_PAGE;
                end
            end
            S_PAGE: begin
                n_state = S_IDLE;
                n_evict = 1'b0;
                n_gone  = '0;
                if (r_oor) begin
                    n_valid     = 1'b1;
                    n_frame_out = '0;
                    n_fault     = 1'b0;
                end else if (pm_rdata[FW]) begin
                    // Hit: the page entry already holds the frame.
                    n_valid     = 1'b1;
                    n_frame_out = OFW'(pm_rdata[FW-1:0]);
                    n_fault     = 1'b0;
                end else if (r_fill < CW'(NUM_FRAMES)) begin
                    // Fault with a free frame left: take the next one in order.
                    pm_we       = 1'b1;
                    pm_wdata    = {1'b1, w_free};
                    ow_we       = 1'b1;
                    ow_addr     = w_free;
                    n_fill      = r_fill + 1'b1;
                    n_valid     = 1'b1;
                    n_frame_out = OFW'(w_free);
                    n_fault     = 1'b1;
                end else begin
                    // All frames busy: look up who owns the victim frame.
                    n_state = S_OWNER;
                end
            end
            S_OWNER: begin
                n_owner = ow_rdata;
                pm_addr = ow_rdata;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                // Unmap the owner only if its entry still points at the victim.
                if (pm_rdata[FW] && (pm_rdata[FW-1:0] == r_victim)) begin
                    pm_we   = 1'b1;
                    pm_addr = r_owner;
                    pm_wdata = '0;
                end
                n_state = S_MAP;
            end
            S_MAP: begin
                pm_we       = 1'b1;
                pm_wdata    = {1'b1, r_victim};
                ow_we       = 1'b1;
                n_valid     = 1'b1;
                n_frame_out = OFW'(r_victim);
                n_fault     = 1'b1;
                n_evict     = 1'b1;
                n_gone      = OPW'(r_owner);
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_fill  <= n_fill;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page      <= n_page;
        r_victim    <= n_victim;
        r_oor       <= n_oor;
        r_owner     <= n_owner;
        r_frame_out <= n_frame_out;
        r_fault     <= n_fault;
        r_evict     <= n_evict;
        r_gone      <= n_gone;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_frame_index  = r_frame_out;
    assign o_page_fault   = r_fault;
    assign o_did_evict    = r_evict;
    assign o_evicted_page = r_gone;

    // An accepted access keeps the block busy until its result is shown.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted access did not raise busy");

    // A result is shown only once the sequencer has returned to idle.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while sequencer busy");

    // An eviction is always a fault and happens only with every frame in use.
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_did_evict) |-> (o_page_fault && (r_fill == CW'(NUM_FRAMES))))
        else $error("eviction without a full frame set");

    // The fill count never passes the number of frames.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(NUM_FRAMES))
        else $error("frame fill count out of range");

endmodule
